// File: rtl/exchange_response_deframer_unit_assert.svh
// Assertion macros used by the deframer's checker file.
// Needs only a clock named clock and a reset named reset in the including scope.
`ifndef EXCHANGE_RESPONSE_DEFRAMER_UNIT_ASSERT_SVH
`define EXCHANGE_RESPONSE_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ERD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define ERD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/erd_pkg.sv
// Shared types, constants and header tables of the exchange response deframer.
// No dependencies; imported by every module of the block.
package erd_pkg;

   // Id field sizes in bytes (each 1..8); only the low four bytes of an id are kept.
   localparam int CLIENT_ID_BYTES = 4;
   localparam int ORDER_ID_BYTES  = 4;
   localparam int OK_ID_TOTAL     = CLIENT_ID_BYTES + ORDER_ID_BYTES;
   localparam int ID_W            = 32;
   localparam int ID_LANES        = ID_W / 8;

   localparam int OK_HDR_LEN  = 12;
   localparam int ERR_HDR_LEN = 15;
   localparam int POS_W       = 8;
   localparam int HDR_IDX_W   = 4;

   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [7:0] GARBAGE_RESET = 8'd64;

   // Frame kind codes.
   localparam logic [1:0] KIND_OK   = 2'd0;
   localparam logic [1:0] KIND_ERR  = 2'd1;
   localparam logic [1:0] KIND_DROP = 2'd2;

   // Register index decode (address bit 2).
   localparam logic CSR_IDX_GARBAGE = 1'b0;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_OK,
      PH_ERR,
      PH_DROP
   } phase_type;

   typedef struct packed {
      logic [1:0]      frame_kind;
      logic [ID_W-1:0] client_ident;
      logic [ID_W-1:0] order_ident;
      logic [7:0]      message_length;
      logic            message_too_long;
   } result_type;

   // "EXCHANGE\nOK\n"
   function automatic logic [7:0] ok_hdr_char(input logic [HDR_IDX_W-1:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0:    c = "E";
         4'd1:    c = "X";
         4'd2:    c = "C";
         4'd3:    c = "H";
         4'd4:    c = "A";
         4'd5:    c = "N";
         4'd6:    c = "G";
         4'd7:    c = "E";
         4'd8:    c = NEWLINE_CHAR;
         4'd9:    c = "O";
         4'd10:   c = "K";
         4'd11:   c = NEWLINE_CHAR;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // "EXCHANGE\nERROR\n"
   function automatic logic [7:0] err_hdr_char(input logic [HDR_IDX_W-1:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0:    c = "E";
         4'd1:    c = "X";
         4'd2:    c = "C";
         4'd3:    c = "H";
         4'd4:    c = "A";
         4'd5:    c = "N";
         4'd6:    c = "G";
         4'd7:    c = "E";
         4'd8:    c = NEWLINE_CHAR;
         4'd9:    c = "E";
         4'd10:   c = "R";
         4'd11:   c = "R";
         4'd12:   c = "O";
         4'd13:   c = "R";
         4'd14:   c = NEWLINE_CHAR;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// File: rtl/erd_parse.sv
// Frame parser core: header match, id collection, message count, drop count.
// Depends on erd_pkg; one byte per step, emits at most one result per step.
module erd_parse (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         data_byte,
   input  logic [7:0]         garbage_frame_bytes,
   output logic               emit,
   output erd_pkg::result_type result
);
   import erd_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [POS_W-1:0]   pos_ff, pos_in, pos_inc;
   logic               okm_ff, okm_in, errm_ff, errm_in;
   logic               ok_hit, err_hit;
   logic [ID_W-1:0]    client_ff, client_in, order_ff, order_in;
   logic [7:0]         cnt_ff, cnt_in;
   logic               ovf_ff, ovf_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         pos_ff    <= '0;
         okm_ff    <= 1'b1;
         errm_ff   <= 1'b1;
         client_ff <= '0;
         order_ff  <= '0;
         cnt_ff    <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         okm_ff    <= okm_in;
         errm_ff   <= errm_in;
         client_ff <= client_in;
         order_ff  <= order_in;
         cnt_ff    <= cnt_in;
         ovf_ff    <= ovf_in;
      end
   end

   always_comb begin
      pos_inc = pos_ff + POS_W'(1);
      ok_hit  = okm_ff && (pos_ff < POS_W'(OK_HDR_LEN))
                && (data_byte == ok_hdr_char(pos_ff[HDR_IDX_W-1:0]));
      err_hit = errm_ff && (pos_ff < POS_W'(ERR_HDR_LEN))
                && (data_byte == err_hdr_char(pos_ff[HDR_IDX_W-1:0]));

      phase_in  = phase_ff;
      pos_in    = pos_ff;
      okm_in    = okm_ff;
      errm_in   = errm_ff;
      client_in = client_ff;
      order_in  = order_ff;
      cnt_in    = cnt_ff;
      ovf_in    = ovf_ff;
      emit      = 1'b0;
      result    = '0;

      if (step) begin
         unique case (phase_ff)
            PH_HEADER: begin
               okm_in  = ok_hit;
               errm_in = err_hit;
               pos_in  = pos_inc;
               priority if (ok_hit && pos_inc == POS_W'(OK_HDR_LEN)) begin
                  phase_in  = PH_OK;
                  pos_in    = '0;
                  client_in = '0;
                  order_in  = '0;
               end else if (err_hit && pos_inc == POS_W'(ERR_HDR_LEN)) begin
                  phase_in = PH_ERR;
                  pos_in   = '0;
                  cnt_in   = '0;
                  ovf_in   = 1'b0;
               end else if (!ok_hit && !err_hit) begin
                  phase_in = PH_DROP;
                  if (pos_inc >= garbage_frame_bytes) begin
                     emit              = 1'b1;
                     result.frame_kind = KIND_DROP;
                  end
               end
            end
            PH_OK: begin
               // Little-endian lanes; bytes past the fourth are consumed only.
               for (int i = 0; i < ID_LANES; i++) begin
                  if (i < CLIENT_ID_BYTES && pos_ff == POS_W'(i))
                     client_in[8*i +: 8] = data_byte;
                  if (i < ORDER_ID_BYTES && pos_ff == POS_W'(CLIENT_ID_BYTES + i))
                     order_in[8*i +: 8] = data_byte;
               end
               pos_in = pos_inc;
               if (pos_inc >= POS_W'(OK_ID_TOTAL)) begin
                  emit                = 1'b1;
                  result.frame_kind   = KIND_OK;
                  result.client_ident = client_in;
                  result.order_ident  = order_in;
               end
            end
            PH_ERR: begin
               if (data_byte == NEWLINE_CHAR) begin
                  emit                    = 1'b1;
                  result.frame_kind       = KIND_ERR;
                  result.message_length   = cnt_ff;
                  result.message_too_long = ovf_ff;
               end else if (cnt_ff == 8'hFF) begin
                  ovf_in = 1'b1;
               end else begin
                  cnt_in = cnt_ff + 8'd1;
               end
            end
            PH_DROP: begin
               pos_in = pos_inc;
               if (pos_inc >= garbage_frame_bytes || pos_inc == '0) begin
                  emit              = 1'b1;
                  result.frame_kind = KIND_DROP;
               end
            end
         endcase

         // Start a new frame after any result.
         if (emit) begin
            phase_in  = PH_HEADER;
            pos_in    = '0;
            okm_in    = 1'b1;
            errm_in   = 1'b1;
            client_in = '0;
            order_in  = '0;
            cnt_in    = '0;
            ovf_in    = 1'b0;
         end
      end
   end

endmodule

// File: rtl/erd_rsp_queue.sv
// Two-slot result buffer: head register drives the port, spare absorbs a stall.
// Depends on erd_pkg for the result struct.
module erd_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  erd_pkg::result_type push_data,
   output logic                space,
   output logic                out_valid,
   input  logic                out_ready,
   output erd_pkg::result_type out_data
);
   import erd_pkg::*;

   result_type head_ff, head_in, spare_ff, spare_in;
   logic       head_v_ff, head_v_in, spare_v_ff, spare_v_in;
   logic       pop;

   assign pop       = head_v_ff && out_ready;
   assign space     = !spare_v_ff || out_ready;
   assign out_valid = head_v_ff;
   assign out_data  = head_ff;

   always_comb begin
      head_in    = head_ff;
      head_v_in  = head_v_ff;
      spare_in   = spare_ff;
      spare_v_in = spare_v_ff;
      if (pop) begin
         head_in    = spare_ff;
         head_v_in  = spare_v_ff;
         spare_v_in = 1'b0;
      end
      if (push) begin
         if (!head_v_in) begin
            head_in   = push_data;
            head_v_in = 1'b1;
         end else begin
            spare_in   = push_data;
            spare_v_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_v_ff  <= 1'b0;
         spare_v_ff <= 1'b0;
      end else begin
         head_v_ff  <= head_v_in;
         spare_v_ff <= spare_v_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff  <= head_in;
      spare_ff <= spare_in;
   end

endmodule

// File: rtl/exchange_response_deframer_unit.sv
// Exchange response deframer top level: request register, parser, result buffer, CSR.
// Depends on erd_pkg, erd_parse and erd_rsp_queue.
//
// Takes the response stream one byte per request and returns one response per finished
// frame. A frame opening with "EXCHANGE\nOK\n" yields kind OK with the little-endian
// client and order ids; one opening with "EXCHANGE\nERROR\n" yields kind error with the
// message length up to the newline (saturating at 255, with a too-long flag); any other
// opening is dropped as one unrecognized frame of garbage_frame_bytes bytes (register 0,
// byte address 0, reset 64), counted from its first byte. Throughput is one byte per
// cycle while the result buffer has space: the parser handles each byte combinationally
// between the request register and the two-slot result buffer, which registers each
// response. Requests keep flowing while one response waits; the request side stalls
// only when both buffer slots are full and the response side is not ready.
// Write the register only while the block is idle.
module exchange_response_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_frame_kind,
   output logic [31:0] rsp_client_ident,
   output logic [31:0] rsp_order_ident,
   output logic [7:0]  rsp_message_length,
   output logic        rsp_message_too_long,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import erd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic [7:0] garbage_ff, garbage_in;
   logic       step, space, emit, csr_write;
   result_type parse_result, head_result;

   // Advance the request register whenever the parser can take its byte.
   assign step      = in_valid_ff && space;
   assign req_ready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (step)
         in_valid_in = 1'b0;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   // CSR: one register; address bit 2 selects the index, other indices are ignored.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      garbage_in = garbage_ff;
      if (csr_write && csr_paddr[2] == CSR_IDX_GARBAGE)
         garbage_in = csr_pwdata[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         garbage_ff <= GARBAGE_RESET;
      end else begin
         garbage_ff <= garbage_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_GARBAGE) ? {24'd0, garbage_ff} : 32'd0;

   erd_parse u_parse (
      .clock               (clock),
      .reset               (reset),
      .step                (step),
      .data_byte           (in_byte_ff),
      .garbage_frame_bytes (garbage_ff),
      .emit                (emit),
      .result              (parse_result)
   );

   erd_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_data (parse_result),
      .space     (space),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (head_result)
   );

   assign rsp_frame_kind       = head_result.frame_kind;
   assign rsp_client_ident     = head_result.client_ident;
   assign rsp_order_ident      = head_result.order_ident;
   assign rsp_message_length   = head_result.message_length;
   assign rsp_message_too_long = head_result.message_too_long;

endmodule

// File: rtl/erd_checker.sv
// Port-level checks of the exchange response deframer, bound to its top level.
// Depends on erd_pkg and the assertion macro header.
`include "exchange_response_deframer_unit_assert.svh"

module erd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic [1:0]  rsp_frame_kind,
   input logic [31:0] rsp_client_ident,
   input logic [31:0] rsp_order_ident,
   input logic [7:0]  rsp_message_length,
   input logic        rsp_message_too_long,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [2:0]  csr_paddr,
   input logic [31:0] csr_pwdata,
   input logic [31:0] csr_prdata,
   input logic        csr_pready
);
   import erd_pkg::*;

   `ERD_ASSERT_IMP(a_kind_legal, rsp_valid,
      rsp_frame_kind == KIND_OK || rsp_frame_kind == KIND_ERR || rsp_frame_kind == KIND_DROP,
      "response kind out of range")
   `ERD_ASSERT_IMP(a_ids_only_ok, rsp_valid && rsp_frame_kind != KIND_OK,
      rsp_client_ident == 32'd0 && rsp_order_ident == 32'd0,
      "ids set on a non-OK response")
   `ERD_ASSERT_IMP(a_msg_only_err, rsp_valid && rsp_frame_kind != KIND_ERR,
      rsp_message_length == 8'd0 && !rsp_message_too_long,
      "message fields set on a non-error response")
   `ERD_ASSERT_IMP(a_too_long_sat, rsp_valid && rsp_message_too_long,
      rsp_message_length == 8'hFF, "too-long flag without saturated length")
   `ERD_ASSERT_NEXT(a_csr_readback,
      csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr[2] == CSR_IDX_GARBAGE,
      csr_paddr[2] != CSR_IDX_GARBAGE || csr_prdata == {24'd0, $past(csr_pwdata[7:0])},
      "register read does not return the written value")

endmodule

bind exchange_response_deframer_unit erd_checker u_erd_checker (.*);
